/* sv/pse_pkg.sv */
// ----------------------------------------------------------------------------
// PDF literal string extractor package
// Shared types, character codes and sizing constants for the extractor core.
// ----------------------------------------------------------------------------
package pse_pkg;

    // Nesting depth bound and the width of the depth counter.
    localparam int MAX_NESTING = 255;
    localparam int NEST_W      = $clog2(MAX_NESTING + 1);

    // Most result items that one input item can cause.
    localparam int RES_MAX   = 3;
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    // Result queue sizing.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // Input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_t;

    // Parser state carried from one input item to the next.
    typedef struct packed {
        logic              inside_string;
        logic [NEST_W-1:0] nest_level;
        logic              escape_pending;
        logic [1:0]        octal_digits_seen;
        logic [7:0]        octal_accum;
        logic              output_started;
        logic              last_was_blank;
        logic              string_has_output;
    } state_t;

endpackage

/* sv/pse_step.sv */
// ----------------------------------------------------------------------------
// PDF literal string extractor step logic
// Works out the next parser state and up to three result items for one byte.
// ----------------------------------------------------------------------------
module pse_step
    import pse_pkg::*;
(
    input  state_t                      st,
    input  in_t                         item,
    output state_t                      st_next,
    output logic [RES_CNT_W-1:0]        res_cnt,
    output out_t [RES_MAX-1:0]          res
);

    logic [7:0]        c;
    logic              is_oct;
    logic              oct_v;
    logic [7:0]        oct_byte;
    logic              own_v;
    logic [7:0]        own_byte;
    logic              sep_v;
    logic [7:0]        acc_shift;
    logic [NEST_W-1:0] nest_dec;
    logic [RES_CNT_W-1:0] idx;

    assign c      = item.in_byte;
    assign is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);

    // Decode the byte against the current state.
    always_comb begin
        st_next   = st;
        oct_v     = 1'b0;
        oct_byte  = '0;
        own_v     = 1'b0;
        own_byte  = '0;
        acc_shift = {st.octal_accum[4:0], c[2:0]};
        nest_dec  = (st.nest_level != '0) ? st.nest_level - NEST_W'(1) : st.nest_level;

        priority if (!st.inside_string) begin
            // Outside a string only an opening parenthesis matters.
            if (c == CH_LPAREN) begin
                st_next.inside_string     = 1'b1;
                st_next.nest_level        = NEST_W'(1);
                st_next.string_has_output = 1'b0;
            end
        end else if (st.escape_pending) begin
            // Byte following a backslash.
            st_next.escape_pending = 1'b0;
            priority if (c == CH_N) begin
                own_v    = 1'b1;
                own_byte = CH_LF;
            end else if (c == CH_R) begin
                own_v    = 1'b1;
                own_byte = CH_CR;
            end else if (c == CH_T) begin
                own_v    = 1'b1;
                own_byte = CH_TAB;
            end else if (is_oct) begin
                st_next.octal_accum       = {5'b0, c[2:0]};
                st_next.octal_digits_seen = 2'd1;
            end else begin
                own_v    = 1'b1;
                own_byte = c;
            end
        end else if ((st.octal_digits_seen != 2'd0) && is_oct) begin
            // Further octal digit; the third one completes the byte.
            if (st.octal_digits_seen == 2'd2) begin
                oct_v                     = 1'b1;
                oct_byte                  = acc_shift;
                st_next.octal_digits_seen = 2'd0;
                st_next.octal_accum       = '0;
            end else begin
                st_next.octal_accum       = acc_shift;
                st_next.octal_digits_seen = 2'd2;
            end
        end else begin
            // Any other byte ends an octal run first.
            if (st.octal_digits_seen != 2'd0) begin
                oct_v                     = 1'b1;
                oct_byte                  = st.octal_accum;
                st_next.octal_digits_seen = 2'd0;
                st_next.octal_accum       = '0;
            end
            priority if (c == CH_BACKSLASH) begin
                if (item.end_of_data) begin
                    own_v    = 1'b1;
                    own_byte = c;
                end else begin
                    st_next.escape_pending = 1'b1;
                end
            end else if (c == CH_LPAREN) begin
                if (st.nest_level < NEST_W'(MAX_NESTING)) begin
                    st_next.nest_level = st.nest_level + NEST_W'(1);
                end
                own_v    = 1'b1;
                own_byte = c;
            end else if (c == CH_RPAREN) begin
                st_next.nest_level = nest_dec;
                if (nest_dec == '0) begin
                    st_next.inside_string = 1'b0;
                end else begin
                    own_v    = 1'b1;
                    own_byte = c;
                end
            end else begin
                own_v    = 1'b1;
                own_byte = c;
            end
        end

        // At the end of data a pending octal run is flushed. No other text is
        // produced by the item in that case, so the octal slot is free.
        if (item.end_of_data && (st_next.octal_digits_seen != 2'd0)) begin
            oct_v    = 1'b1;
            oct_byte = st_next.octal_accum;
        end

        // A separator goes before the first text of a string.
        sep_v = (oct_v || own_v) && !st.string_has_output && st.output_started
                && !st.last_was_blank;

        // Output history.
        if (oct_v || own_v) begin
            st_next.string_has_output = 1'b1;
            st_next.output_started    = 1'b1;
        end
        if (own_v) begin
            st_next.last_was_blank = (own_byte == CH_SPACE) || (own_byte == CH_LF);
        end else if (oct_v) begin
            st_next.last_was_blank = (oct_byte == CH_SPACE) || (oct_byte == CH_LF);
        end

        // End of data returns everything to the reset state.
        if (item.end_of_data) begin
            st_next = '0;
        end
    end

    // Pack the result items in order: separator, octal byte, own byte.
    always_comb begin
        res = '0;
        idx = '0;
        if (sep_v) begin
            res[idx].out_byte = CH_SPACE;
            idx = idx + RES_CNT_W'(1);
        end
        if (oct_v) begin
            res[idx].out_byte = oct_byte;
            idx = idx + RES_CNT_W'(1);
        end
        if (own_v) begin
            res[idx].out_byte = own_byte;
            idx = idx + RES_CNT_W'(1);
        end
        for (int k = 0; k < RES_MAX; k++) begin
            res[k].run_last = (RES_CNT_W'(k + 1) == idx);
        end
        res_cnt = idx;
    end

endmodule

/* sv/pse_result_queue.sv */
// ----------------------------------------------------------------------------
// PDF literal string extractor result queue
// Small register queue that takes up to three result items a cycle and
// presents one a cycle on the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module pse_result_queue
    import pse_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [RES_CNT_W-1:0] push_cnt,
    input  out_t [RES_MAX-1:0]   push_data,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    out_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 pop;

    // Room for a worst-case burst from one item.
    assign room    = (count_reg <= Q_CNT_W'(Q_DEPTH - RES_MAX));
    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; each pushed item lands in its own slot.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (RES_CNT_W'(k) < push_cnt) begin
                mem_reg[wr_ptr_reg + Q_PTR_W'(k)] <= push_data[k];
            end
        end
    end

endmodule

/* sv/pdf_literal_string_extractor_core.sv */
// Path: input register, step logic, then the result queue to the result channel.
// Throughput: one input item per cycle while each item gives at most one result;
// an item with more results holds the result channel for each of them in turn,
// and the input side stalls once the four-entry result queue cannot take a burst.
// Reset: synchronous, active low; clears the parser state, the input register
// and the result queue.
// ----------------------------------------------------------------------------
// PDF literal string extractor core
// Extracts the text of literal strings from a document byte stream, with
// escape and octal decoding and separator spaces between strings.
// ----------------------------------------------------------------------------
module pdf_literal_string_extractor_core
    import pse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    in_t                  in_reg;
    logic                 in_valid_reg;
    state_t               st_reg;
    state_t               st_next;
    logic [RES_CNT_W-1:0] res_cnt;
    out_t [RES_MAX-1:0]   res;
    logic                 room;
    logic                 consume;
    logic [RES_CNT_W-1:0] push_cnt;

    // The held item is processed once the queue has room for its results.
    assign consume  = in_valid_reg && room;
    assign s_ready  = !in_valid_reg || consume;
    assign push_cnt = consume ? res_cnt : '0;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Parser state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (consume) begin
            st_reg <= st_next;
        end
    end

    pse_step u_step (
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next),
        .res_cnt (res_cnt),
        .res     (res)
    );

    pse_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* sv/pse_checker.sv */
// ----------------------------------------------------------------------------
// PDF literal string extractor checker
// Port-level assertions on the extractor core, attached by a bind statement.
// ----------------------------------------------------------------------------
module pse_checker
    import pse_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    logic [1:0] run_len_reg;

    // Count result items since the last one that closed a run.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
        end else if (m_valid && m_ready) begin
            run_len_reg <= m_data.run_last ? 2'd0 : run_len_reg + 2'd1;
        end
    end

    // A waiting input item holds its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // No input item gives more than three result items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |-> run_len_reg < 2'd2)
        else $error("run of result items longer than three");

    // Reset empties the result queue.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item present after reset");

    // Reset leaves the input side ready.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind pdf_literal_string_extractor_core pse_checker u_pse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the PDF literal string extractor core
// Drives document bytes through the valid/ready input channel, decodes the
// same bytes in a behavioural parser of its own, and checks every text item
// that leaves the core against the decoded text, in order and field by field.
// ----------------------------------------------------------------------------
module tb
    import pse_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEMS        = 400;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    // One queued input item with its idle gap and an optional drain request.
    typedef struct packed {
        in_t        item;
        logic [3:0] gap;
        logic       drain;
    } pending_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    pdf_literal_string_extractor_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Stimulus and scoreboard storage.
    pending_t   pending_bytes[$];
    out_t       expected_text[$];
    logic [7:0] burst_bytes[$];
    int         pending_total  = 0;
    int         items_accepted = 0;
    int         results_seen   = 0;
    int         fault_count    = 0;
    bit         send_calm      = 1'b0;
    bit         recv_calm      = 1'b0;
    bit         next_drain     = 1'b0;

    // Parser state of the behavioural decoder.
    bit         in_string;
    int         depth;
    bit         escape_armed;
    int         octal_count;
    logic [7:0] octal_value;
    bit         text_started;
    bit         last_blank;
    bit         string_emitted;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Behavioural decoder
    // ------------------------------------------------------------------

    task automatic clear_parser();
        in_string      = 1'b0;
        depth          = 0;
        escape_armed   = 1'b0;
        octal_count    = 0;
        octal_value    = '0;
        text_started   = 1'b0;
        last_blank     = 1'b0;
        string_emitted = 1'b0;
    endtask

    task automatic emit_raw(logic [7:0] c);
        burst_bytes.insert(burst_bytes.size(), c);
        text_started = 1'b1;
        last_blank   = (c == CH_SPACE) || (c == CH_LF);
    endtask

    // The first byte of a string is preceded by a separating space unless the
    // text so far is empty or already ends in a space or line feed.
    task automatic emit_text(logic [7:0] c);
        if (!string_emitted) begin
            if (text_started && !last_blank) begin
                emit_raw(CH_SPACE);
            end
            string_emitted = 1'b1;
        end
        emit_raw(c);
    endtask

    task automatic flush_octal();
        if (octal_count != 0) begin
            emit_text(octal_value);
            octal_count = 0;
            octal_value = '0;
        end
    endtask

    function automatic bit is_octal_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // Decodes one accepted input item and queues the text items it causes.
    task automatic decode_byte(in_t it);
        logic [7:0] c;
        bit         eod;
        out_t       r;
        c   = it.in_byte;
        eod = it.end_of_data;
        burst_bytes.delete();
        if (!in_string) begin
            if (c == CH_LPAREN) begin
                in_string      = 1'b1;
                depth          = 1;
                string_emitted = 1'b0;
            end
        end else if (escape_armed) begin
            escape_armed = 1'b0;
            case (c)
                CH_N: emit_text(CH_LF);
                CH_R: emit_text(CH_CR);
                CH_T: emit_text(CH_TAB);
                default: begin
                    if (is_octal_digit(c)) begin
                        octal_value = c - CH_ZERO;
                        octal_count = 1;
                    end else begin
                        emit_text(c);
                    end
                end
            endcase
        end else if (octal_count != 0 && is_octal_digit(c)) begin
            // Only the low eight bits of the octal value are kept.
            octal_value = {octal_value[4:0], 3'b000} + (c - CH_ZERO);
            octal_count++;
            if (octal_count >= 3) begin
                flush_octal();
            end
        end else begin
            flush_octal();
            if (c == CH_BACKSLASH) begin
                if (eod) begin
                    emit_text(c);
                end else begin
                    escape_armed = 1'b1;
                end
            end else if (c == CH_LPAREN) begin
                if (depth < MAX_NESTING) begin
                    depth++;
                end
                emit_text(c);
            end else if (c == CH_RPAREN) begin
                if (depth > 0) begin
                    depth--;
                end
                if (depth == 0) begin
                    in_string = 1'b0;
                end else begin
                    emit_text(c);
                end
            end else begin
                emit_text(c);
            end
        end
        if (eod) begin
            flush_octal();
            clear_parser();
        end
        foreach (burst_bytes[i]) begin
            r.out_byte = burst_bytes[i];
            r.run_last = (i == burst_bytes.size() - 1);
            expected_text.insert(expected_text.size(), r);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic push_item(logic [7:0] b, logic eod);
        pending_t p;
        if ($urandom_range(0, 24) == 0) begin
            send_calm = !send_calm;
        end
        p.item.in_byte     = b;
        p.item.end_of_data = eod;
        p.gap              = send_calm ? 4'd0 : 4'($urandom_range(0, 14));
        p.drain            = next_drain;
        next_drain         = 1'b0;
        pending_bytes.insert(pending_bytes.size(), p);
        pending_total++;
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], 1'b0);
        end
    endtask

    // Plain string text, biased towards spaces, line feeds and letters.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_SPACE;
            1:       c = CH_LF;
            2:       c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(8'h41, 8'h7A));
        endcase
        if (c == CH_LPAREN || c == CH_RPAREN || c == CH_BACKSLASH) begin
            c = c ^ 8'h40;
        end
        return c;
    endfunction

    // One literal string with random content and nesting, preceded by some
    // bytes outside any string. Sometimes the data ends part way through.
    task automatic add_string();
        int         opened;
        int         tok;
        int         ndig;
        logic [7:0] b;
        repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom_range(0, 255));
            push_item((b == CH_LPAREN) ? CH_RPAREN : b, 1'b0);
        end
        push_item(CH_LPAREN, 1'b0);
        opened = 1;
        repeat ($urandom_range(0, 12)) begin
            tok = int'($urandom_range(0, 99));
            if (tok < 10) begin
                push_item(CH_LPAREN, 1'b0);
                opened++;
            end else if (tok < 18 && opened > 1) begin
                push_item(CH_RPAREN, 1'b0);
                opened--;
            end else if (tok < 30) begin
                push_item(CH_BACKSLASH, 1'b0);
                case ($urandom_range(0, 3))
                    0:       push_item(CH_N, 1'b0);
                    1:       push_item(CH_R, 1'b0);
                    2:       push_item(CH_T, 1'b0);
                    default: push_item(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end else if (tok < 42) begin
                push_item(CH_BACKSLASH, 1'b0);
                ndig = int'($urandom_range(1, 3));
                repeat (ndig) push_item(8'($urandom_range(CH_ZERO, CH_SEVEN)), 1'b0);
                if ($urandom_range(0, 2) == 0) begin
                    push_item(8'($urandom_range(CH_ZERO, CH_SEVEN)), 1'b0);
                end
            end else if (tok < 44) begin
                push_item(CH_BACKSLASH, 1'b1);
                return;
            end else if (tok < 46) begin
                push_item(CH_BACKSLASH, 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1);
                return;
            end else if (tok < 49) begin
                push_item(8'($urandom_range(0, 255)), 1'b1);
                return;
            end else begin
                push_item(text_byte(), 1'b0);
            end
        end
        repeat (opened) push_item(CH_RPAREN, 1'b0);
        if ($urandom_range(0, 7) == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued items, predicts each accepted one
    // ------------------------------------------------------------------
    int send_wait = -1;

    always @(posedge aclk) begin
        pending_t head;
        bit       offering;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_data    <= '0;
            send_wait = -1;
            clear_parser();
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                items_accepted++;
                offering = 1'b0;
            end
            if (!offering && pending_bytes.size() > 0) begin
                head = pending_bytes[0];
                if (send_wait < 0) begin
                    send_wait = int'(head.gap);
                end
                // A drain request holds the item until all text has arrived.
                if (head.drain && expected_text.size() > 0) begin
                    send_wait = send_wait;
                end else if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    void'(pending_bytes.pop_front());
                    s_data    <= head.item;
                    offering  = 1'b1;
                    send_wait = -1;
                end
            end
            s_valid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    int recv_wait   = 0;
    int hold_cycles = 0;

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            recv_wait   = 0;
            hold_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_text.size() == 0) begin
                    $error("unexpected item: out_byte %h run_last %b",
                           m_data.out_byte, m_data.run_last);
                    fault_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h",
                               want.out_byte, m_data.out_byte);
                        fault_count++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b",
                               want.run_last, m_data.run_last);
                        fault_count++;
                    end
                end
                if ($urandom_range(0, 29) == 0) begin
                    recv_calm = !recv_calm;
                end
                recv_wait = recv_calm ? 0 : int'($urandom_range(0, 14));
                // One long stall so the result queue fills and the input stalls.
                if (results_seen == HOLD_AT) begin
                    hold_cycles = HOLD_CYCLES;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed: byte extremes outside a string, every escape, octal runs
        // cut short and complete, text brackets, an empty string, and data
        // ending on a backslash or in the middle of an octal run.
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_str("(A\\n\\r)");
        push_str("(\\t\\777)");
        push_str("(\\4()\\))");
        push_str("()");
        push_str("(\\5");
        push_item(CH_BACKSLASH, 1'b1);
        push_str("(\\6");
        push_item(8'h31, 1'b1);

        // Random strings, leaving room for the nesting run below.
        next_drain = 1'b1;
        while (pending_total < ITEMS - MAX_NESTING - 8) add_string();
        next_drain = 1'b1;

        // Nesting beyond the depth bound; the closing brackets that follow
        // are still text, and the data then ends inside the string.
        push_item(CH_LPAREN, 1'b0);
        repeat (MAX_NESTING) push_item(CH_LPAREN, 1'b0);
        push_item(text_byte(), 1'b0);
        repeat (2) push_item(CH_RPAREN, 1'b0);
        push_item(text_byte(), 1'b1);

        push_item(8'($urandom_range(0, 255)), 1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < pending_total) @(posedge aclk);
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d document bytes and %0d text items: escapes, octal runs,",
                 items_accepted, results_seen);
        $display("nesting past the depth bound, end-of-data flushes and long output stalls.");
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
